// ----- hdl/rrb_pkg.sv -----
// Shared types and constants for the receive ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package rrb_pkg;

    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int AMT_W  = 16;
    localparam int FILL_W = 10;
    localparam int SIZE_W = 11;

    localparam int DEFAULT_DEPTH = 1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_RING_LEN = '0;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PULL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SKIP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_PULL,
        OP_PEEK,
        OP_SKIP,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data_byte;
        logic [AMT_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0] ring_len;
        logic              restart;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hdl/rrb_ifs.sv -----
// Request and result channel interfaces of the receive ring buffer.
`timescale 1ns / 1ps
`default_nettype none

interface rrb_in_if;
    logic                       valid;
    logic                       ready;
    logic [rrb_pkg::MODE_W-1:0] mode;
    logic [rrb_pkg::BYTE_W-1:0] data_byte;
    logic [rrb_pkg::AMT_W-1:0]  amount;

    modport source (output valid, mode, data_byte, amount, input ready);
    modport sink (input valid, mode, data_byte, amount, output ready);
endinterface

interface rrb_out_if;
    logic                       valid;
    logic                       ready;
    logic [rrb_pkg::BYTE_W-1:0] read_byte;
    logic                       byte_valid;
    logic [rrb_pkg::FILL_W-1:0] fill_length;

    modport source (output valid, read_byte, byte_valid, fill_length, input ready);
    modport sink (input valid, read_byte, byte_valid, fill_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/rrb_front.sv -----
// Front stage: takes requests and decodes the mode into an operation.
`timescale 1ns / 1ps
`default_nettype none

module rrb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_enable,
    rrb_in_if.sink        i_rx,
    output logic          o_push,
    output rrb_pkg::t_cmd o_cmd,
    input  logic          i_queue_ready
);
    import rrb_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_op  w_op;

    always_comb begin
        unique case (i_rx.mode)
            MODE_WRITE: w_op = OP_WRITE;
            MODE_PULL:  w_op = OP_PULL;
            MODE_PEEK:  w_op = OP_PEEK;
            MODE_SKIP:  w_op = OP_SKIP;
            MODE_CLEAR: w_op = OP_CLEAR;
            default:    w_op = OP_NOP;
        endcase
    end

    assign i_rx.ready = i_enable && (!r_valid || i_queue_ready);
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_valid         <= 1'b1;
            r_cmd.op        <= w_op;
            r_cmd.data_byte <= i_rx.data_byte;
            r_cmd.amount    <= i_rx.amount;
        end else if (i_queue_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rrb_queue.sv -----
// Short command queue between the front stage and the executor.
`timescale 1ns / 1ps
`default_nettype none

module rrb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rrb_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output rrb_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import rrb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_ready   = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid   = r_count != '0;
    assign o_cmd     = r_slot[r_rd_ptr];
    assign w_do_push = i_push && o_ready;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rrb_rem.sv -----
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rrb_rem #(
    parameter int SW = 11
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rrb_pkg::AMT_W-1:0]  i_dividend,
    input  logic [SW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [SW-1:0]              o_rem
);
    import rrb_pkg::*;

    localparam int CNT_W = $clog2(AMT_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [AMT_W-1:0] r_shift;
    logic [SW-1:0]    r_rem;
    logic [SW:0]      w_trial;

    assign w_trial = {r_rem, r_shift[AMT_W-1]};
    assign o_done  = r_done;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_shift <= i_dividend;
                r_rem   <= '0;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so one compare suffices.
                if (w_trial >= {1'b0, i_divisor}) begin
                    r_rem <= SW'(w_trial - {1'b0, i_divisor});
                end else begin
                    r_rem <= w_trial[SW-1:0];
                end
                r_shift <= r_shift << 1;
                r_cnt   <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(AMT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_divisor))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ----- hdl/rrb_back.sv -----
// Executor: ring memory, positions, operation sequencing and result register.
`timescale 1ns / 1ps
`default_nettype none

module rrb_back #(
    parameter int BUFFER_DEPTH = rrb_pkg::DEFAULT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rrb_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  rrb_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_clearing,
    rrb_out_if.source     o_res
);
    import rrb_pkg::*;

    localparam int PW    = $clog2(BUFFER_DEPTH);
    localparam int SW    = $clog2(BUFFER_DEPTH + 1);
    localparam int SW1   = SW + 1;
    localparam int CMP_W = AMT_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SKIP,
        S_STEP,
        S_MOD,
        S_PIDX,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_rp;
    logic [PW-1:0]     r_clr_idx;
    t_cmd              r_cmd;
    logic [SW-1:0]     r_step;
    logic [SW1-1:0]    r_idx;
    logic              r_hit;
    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_bvalid;
    logic [FILL_W-1:0] r_out_fill;

    logic [SW-1:0]     w_size;
    logic [SW-1:0]     w_fill;
    logic [31:0]       w_fill32;
    logic [SW-1:0]     w_wp_inc;
    logic [SW-1:0]     w_rp_inc;
    logic [PW-1:0]     w_wp_next;
    logic [PW-1:0]     w_rp_next;
    logic [SW1-1:0]    w_np;
    logic [PW-1:0]     w_pidx;
    logic              w_out_free;
    logic              w_wr_en;
    logic [PW-1:0]     w_wr_addr;
    logic [BYTE_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [PW-1:0]     w_rd_addr;
    logic              w_rem_start;
    logic              w_rem_done;
    logic [SW-1:0]     w_rem;

    // A size of zero acts as one; sizes beyond the memory act as its depth.
    always_comb begin
        if (i_cfg.ring_len == '0) begin
            w_size = SW'(1);
        end else if (32'(i_cfg.ring_len) > BUFFER_DEPTH) begin
            w_size = SW'(BUFFER_DEPTH);
        end else begin
            w_size = SW'(i_cfg.ring_len);
        end
    end

    always_comb begin
        if (r_wp >= r_rp) begin
            w_fill = SW'(r_wp) - SW'(r_rp);
        end else begin
            w_fill = w_size + SW'(r_wp) - SW'(r_rp);
        end
    end

    assign w_fill32  = 32'(w_fill);
    assign w_wp_inc  = SW'(r_wp) + SW'(1);
    assign w_rp_inc  = SW'(r_rp) + SW'(1);
    assign w_wp_next = (w_wp_inc >= w_size) ? '0 : PW'(w_wp_inc);
    assign w_rp_next = (w_rp_inc >= w_size) ? '0 : PW'(w_rp_inc);
    assign w_np      = SW1'(r_rp) + SW1'(r_step);
    assign w_pidx    = (r_idx >= SW1'(w_size)) ? PW'(r_idx - SW1'(w_size)) : PW'(r_idx);

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid;
    assign o_clearing  = r_state == S_CLEAR;
    assign w_rem_start = o_pop && (i_cmd.op == OP_PEEK);

    assign o_res.valid       = r_out_valid;
    assign o_res.read_byte   = r_out_byte;
    assign o_res.byte_valid  = r_out_bvalid;
    assign o_res.fill_length = r_out_fill;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_wp;
        w_wr_data = i_cmd.data_byte;
        w_rd_en   = 1'b0;
        w_rd_addr = r_rp;
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_idx;
            w_wr_data = '0;
        end
        if (o_pop && (i_cmd.op == OP_WRITE)) begin
            w_wr_en = 1'b1;
        end
        if (o_pop && (i_cmd.op == OP_PULL) && (r_rp != r_wp)) begin
            w_rd_en = 1'b1;
        end
        if (r_state == S_PIDX) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_pidx;
        end
    end

    rrb_rem #(
        .SW (SW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (i_cmd.amount),
        .i_divisor  (w_size),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the final state a taken result is replaced by the next one.
            if (o_res.valid && o_res.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == PW'(BUFFER_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + PW'(1);
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_hit <= (i_cmd.op == OP_PULL) && (r_rp != r_wp);
                        unique case (i_cmd.op)
                            OP_WRITE: begin
                                r_wp    <= w_wp_next;
                                r_state <= S_FIN;
                            end
                            OP_PULL: begin
                                if (r_rp != r_wp) begin
                                    r_rp <= w_rp_next;
                                end
                                r_state <= S_FIN;
                            end
                            OP_PEEK:  r_state <= S_MOD;
                            OP_SKIP:  r_state <= S_SKIP;
                            OP_CLEAR: begin
                                r_rp    <= r_wp;
                                r_state <= S_FIN;
                            end
                            default:  r_state <= S_FIN;
                        endcase
                    end
                end
                S_SKIP: begin
                    if (CMP_W'(r_cmd.amount) < CMP_W'(w_fill)) begin
                        r_step <= SW'(r_cmd.amount);
                    end else begin
                        r_step <= w_fill;
                    end
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (w_np >= SW1'(w_size)) begin
                        r_rp <= PW'(w_np - SW1'(w_size));
                    end else begin
                        r_rp <= PW'(w_np);
                    end
                    r_state <= S_FIN;
                end
                S_MOD: begin
                    if (w_rem_done) begin
                        r_idx   <= SW1'(r_rp) + SW1'(w_rem);
                        r_state <= S_PIDX;
                    end
                end
                S_PIDX: begin
                    r_hit   <= 1'b1;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_byte   <= r_hit ? r_rdata : '0;
                        r_out_bvalid <= r_hit;
                        r_out_fill   <= w_fill32[FILL_W-1:0];
                        r_state      <= S_IDLE;
                    end else if (o_res.valid && o_res.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Size write zeroes both positions; keeping it to idle is up to the user.
            if (i_cfg.restart) begin
                r_wp <= '0;
                r_rp <= '0;
            end
        end
    end

    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(r_wp) < w_size) && (SW'(r_rp) < w_size))
        else $error("position outside active ring");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.op == OP_CLEAR) && !i_cfg.restart) |=> (r_rp == r_wp))
        else $error("clear left bytes in the ring");

    a_pull_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.op == OP_PULL) && (r_rp == r_wp)) |=> !r_hit)
        else $error("pull on empty ring returned a byte");

endmodule

`default_nettype wire

// ----- hdl/rx_ring_buffer_with_skip_core.sv -----
// Top level of the receive ring buffer with skip and peek.
//
//  channel   direction  handshake        contents
//  i_rx      in         valid/ready      mode, data_byte, amount
//  o_res     out        valid/ready      read_byte, byte_valid, fill_length
//  APB       in         psel/penable     ring length register at byte address 0
//
// A request passes the front register and the command queue, then executes:
// write, pull, clear and unused modes go straight to the result state, skip first
// clamps the amount and steps the read position, and peek waits for the bit-serial
// remainder of the offset by the size. After reset a clearing pass zeroes the ring;
// no request is taken during it. A result waiting in the output register does not
// stop the front from taking further requests into the queue while it has room.
`timescale 1ns / 1ps
`default_nettype none

module rx_ring_buffer_with_skip_core #(
    parameter int BUFFER_DEPTH = rrb_pkg::DEFAULT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rrb_in_if.sink                      i_rx,
    rrb_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rrb_pkg::APB_AW-1:0]  paddr,
    input  logic [rrb_pkg::APB_DW-1:0]  pwdata,
    output logic [rrb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import rrb_pkg::*;

    logic [SIZE_W-1:0] r_ring_len;
    logic              w_size_sel;
    logic              w_size_wr;
    t_cfg              w_cfg;
    logic              w_clearing;
    logic              w_push;
    t_cmd              w_front_cmd;
    logic              w_queue_ready;
    logic              w_queue_valid;
    t_cmd              w_queue_cmd;
    logic              w_pop;

    assign pready     = 1'b1;
    assign w_size_sel = paddr[APB_AW-1:2] == REG_RING_LEN;
    assign w_size_wr  = psel && penable && pwrite && pready && w_size_sel;
    assign prdata     = w_size_sel ? APB_DW'(r_ring_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_len <= SIZE_RESET;
        end else if (w_size_wr) begin
            r_ring_len <= pwdata[SIZE_W-1:0];
        end
    end

    assign w_cfg.ring_len = r_ring_len;
    assign w_cfg.restart  = w_size_wr;

    rrb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (!w_clearing),
        .i_rx          (i_rx),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd),
        .i_queue_ready (w_queue_ready)
    );

    rrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_ready (w_queue_ready),
        .o_valid (w_queue_valid),
        .o_cmd   (w_queue_cmd),
        .i_pop   (w_pop)
    );

    rrb_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (w_queue_cmd),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
